// File: sv/sjfd_pkg.sv
package sjfd_pkg;

    localparam int SJFD_SLOTS = 16;

    localparam int ID_W    = 8;
    localparam int BURST_W = 16;
    localparam int STAT_W  = 2;

    localparam logic REQ_INSERT   = 1'b0;
    localparam logic REQ_SCHEDULE = 1'b1;

    localparam logic [STAT_W-1:0] STAT_INSERTED = 2'd0;
    localparam logic [STAT_W-1:0] STAT_GRANTED  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd3;

    // first field in the highest bits
    typedef struct packed {
        logic [BURST_W-1:0] later;
        logic [BURST_W-1:0] pred;
        logic [BURST_W-1:0] burst;
        logic [ID_W-1:0]    id;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic   found;
        entry_t ent;
    } token_t;

    typedef struct packed {
        logic valid;
        logic write_en;
        logic shift_en;
    } cell_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

// File: sv/sjfd_cell.sv
module sjfd_cell #(
    parameter int IDX_W = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  sjfd_pkg::cell_ctl_t ctl,
    input  logic [IDX_W-1:0]   cell_index,
    input  sjfd_pkg::entry_t   new_entry,
    input  sjfd_pkg::entry_t   right_entry,
    output sjfd_pkg::entry_t   entry,
    input  sjfd_pkg::token_t   tok_in,
    input  logic [IDX_W-1:0]   tok_idx_in,
    output sjfd_pkg::token_t   tok_out,
    output logic [IDX_W-1:0]   tok_idx_out
);
    import sjfd_pkg::*;

    entry_t           entry_reg;
    entry_t           entry_next;
    token_t           tok_reg;
    token_t           tok_next;
    logic [IDX_W-1:0] tok_idx_reg;
    logic [IDX_W-1:0] tok_idx_next;
    logic             take_own;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.write_en)
        begin
            entry_next = new_entry;
        end
        else if (ctl.shift_en)
        begin
            entry_next = right_entry;
        end
    end

    // strict less keeps the earliest entry on a tie
    assign take_own = ctl.valid && (!tok_in.found || (entry_reg.pred < tok_in.ent.pred));

    always_comb
    begin
        if (take_own)
        begin
            tok_next.found = 1'b1;
            tok_next.ent   = entry_reg;
            tok_idx_next   = cell_index;
        end
        else
        begin
            tok_next     = tok_in;
            tok_idx_next = tok_idx_in;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg   <= entry_next;
        tok_idx_reg <= tok_idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign entry       = entry_reg;
    assign tok_out     = tok_reg;
    assign tok_idx_out = tok_idx_reg;

endmodule

// File: sv/shortest_job_first_dispatcher_unit.sv
// Shortest-job-first dispatcher. Requests arrive on s_* (tuser 0 inserts the entry in tdata,
// tuser 1 schedules one entry) and every request gives exactly one response on m_*, with the
// status in m_tuser. Entries sit in a row of SLOTS cells in insertion order. In a schedule, a
// comparison token walks the cell row one cell per cycle to find the smallest prediction
// (earliest wins a tie), then the chosen entry is removed and the cells behind it all move up
// by one at the same clock edge. Schedule on an empty table skips the scan. One request is in
// work at a time; a response waiting in the output register does not stop the next request
// from being accepted.
module shortest_job_first_dispatcher_unit #(
    parameter int SLOTS = sjfd_pkg::SJFD_SLOTS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // process_id, burst_length, predicted_length, later_prediction
    input  logic        s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // granted_id, dispatched_burst, was_split, remainder_burst,
                                   // remainder_prediction, zero fill
    output logic [1:0]  m_tuser    // status
);
    import sjfd_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [IDX_W-1:0]   scan_reg;
    logic [IDX_W-1:0]   scan_next;
    logic               req_type_reg;
    entry_t             req_entry_reg;
    logic               m_tvalid_reg;
    logic               m_tvalid_next;
    logic [63:0]        m_tdata_reg;
    logic [63:0]        m_tdata_next;
    logic [1:0]         m_tuser_reg;
    logic [1:0]         m_tuser_next;

    logic               accept;
    logic               out_free;
    logic               finish;
    logic               do_insert;
    logic               do_remove;
    logic               split;
    entry_t             pick;
    logic [IDX_W-1:0]   best_idx;

    cell_ctl_t          ctl      [SLOTS];
    entry_t             entries  [SLOTS];
    token_t             toks     [SLOTS+1];
    logic [IDX_W-1:0]   tok_idxs [SLOTS+1];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign finish   = (state_reg == ST_DONE) && out_free;

    assign toks[0]     = '0;
    assign tok_idxs[0] = '0;

    assign pick     = toks[SLOTS].ent;
    assign best_idx = tok_idxs[SLOTS];
    assign split    = pick.burst > pick.pred;

    assign do_insert = finish && (req_type_reg == REQ_INSERT) && (count_reg != CNT_W'(SLOTS));
    assign do_remove = finish && (req_type_reg == REQ_SCHEDULE) && (count_reg != '0);

    genvar k;
    generate
        for (k = 0; k < SLOTS; k++)
        begin : g_cell
            assign ctl[k].valid    = CNT_W'(k) < count_reg;
            assign ctl[k].write_en = do_insert && (count_reg == CNT_W'(k));
            assign ctl[k].shift_en = do_remove && (IDX_W'(k) >= best_idx);

            sjfd_cell #(
                .IDX_W (IDX_W)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ctl[k]),
                .cell_index  (IDX_W'(k)),
                .new_entry   (req_entry_reg),
                .right_entry (entries[(k + 1 < SLOTS) ? k + 1 : k]),
                .entry       (entries[k]),
                .tok_in      (toks[k]),
                .tok_idx_in  (tok_idxs[k]),
                .tok_out     (toks[k+1]),
                .tok_idx_out (tok_idxs[k+1])
            );
        end
    endgenerate

    always_comb
    begin
        state_next    = state_reg;
        scan_next     = scan_reg;
        count_next    = count_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    scan_next = '0;
                    if ((s_tuser == REQ_SCHEDULE) && (count_reg != '0))
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN:
            begin
                scan_next = scan_reg + 1'b1;
                if (scan_reg == IDX_W'(SLOTS - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next    = ST_IDLE;
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    if (req_type_reg == REQ_INSERT)
                    begin
                        if (do_insert)
                        begin
                            m_tuser_next = STAT_INSERTED;
                            count_next   = count_reg + 1'b1;
                        end
                        else
                        begin
                            m_tuser_next = STAT_FULL;
                        end
                    end
                    else if (do_remove)
                    begin
                        m_tuser_next = STAT_GRANTED;
                        count_next   = count_reg - 1'b1;
                        if (split)
                        begin
                            m_tdata_next = {7'd0, pick.later, pick.burst - pick.pred,
                                            1'b1, pick.pred, pick.id};
                        end
                        else
                        begin
                            m_tdata_next = {7'd0, 16'd0, 16'd0, 1'b0, pick.burst, pick.id};
                        end
                    end
                    else
                    begin
                        m_tuser_next = STAT_EMPTY;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            scan_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            scan_reg     <= scan_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_type_reg  <= s_tuser;
            req_entry_reg <= entry_t'(s_tdata);
        end
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// File: sim/sjfd_dispatch_checker.sv
module sjfd_dispatch_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,   // process_id, burst_length, predicted_length, later_prediction
    input  logic        s_tuser,   // req_type
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,   // granted_id, dispatched_burst, was_split, remainder_burst,
                                   // remainder_prediction, zero fill
    input  logic [1:0]  m_tuser,   // status
    output int          fail_count,
    output int          pending
);
    import sjfd_pkg::*;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [ID_W-1:0]    granted_id;
        logic [BURST_W-1:0] dispatched;
        logic               split;
        logic [BURST_W-1:0] rem_burst;
        logic [BURST_W-1:0] rem_pred;
    } dispatch_t;

    entry_t    ready_row [SJFD_SLOTS];
    int        ready_count;
    dispatch_t expected_dispatches [$];

    function automatic dispatch_t predict_dispatch(logic kind, entry_t req);
        dispatch_t r;
        entry_t    pick;
        int        best;
        r = '0;
        if (kind == REQ_INSERT)
        begin
            if (ready_count >= SJFD_SLOTS)
            begin
                r.status = STAT_FULL;
            end
            else
            begin
                ready_row[ready_count] = req;
                ready_count++;
                r.status = STAT_INSERTED;
            end
        end
        else if (ready_count == 0)
        begin
            r.status = STAT_EMPTY;
        end
        else
        begin
            // smallest prediction, earliest entry wins a tie
            best = 0;
            for (int k = 1; k < ready_count; k++)
            begin
                if (ready_row[k].pred < ready_row[best].pred)
                    best = k;
            end
            pick = ready_row[best];
            for (int k = best; k + 1 < ready_count; k++)
                ready_row[k] = ready_row[k + 1];
            ready_count--;
            r.status     = STAT_GRANTED;
            r.granted_id = pick.id;
            if (pick.burst > pick.pred)
            begin
                r.dispatched = pick.pred;
                r.split      = 1'b1;
                r.rem_burst  = pick.burst - pick.pred;
                r.rem_pred   = pick.later;
            end
            else
            begin
                r.dispatched = pick.burst;
            end
        end
        return r;
    endfunction

    task automatic check_field(string label, logic [15:0] exp_v, logic [15:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, label, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        dispatch_t want;
        if (!rst_n)
        begin
            ready_count = 0;
            expected_dispatches.delete();
            fail_count = 0;
            pending <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_dispatches.size() == 0)
                begin
                    $display("%0t: response with none expected, expected none, actual %h/%h",
                             $time, m_tuser, m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = expected_dispatches.pop_front();
                    check_field("status", 16'(want.status), 16'(m_tuser));
                    check_field("granted_id", 16'(want.granted_id), 16'(m_tdata[7:0]));
                    check_field("dispatched_burst", want.dispatched, m_tdata[23:8]);
                    check_field("was_split", 16'(want.split), 16'(m_tdata[24]));
                    check_field("remainder_burst", want.rem_burst, m_tdata[40:25]);
                    check_field("remainder_prediction", want.rem_pred, m_tdata[56:41]);
                    check_field("zero fill", 16'h0, 16'(m_tdata[63:57]));
                end
            end
            if (s_tvalid && s_tready)
                expected_dispatches.push_back(predict_dispatch(s_tuser, entry_t'(s_tdata)));
            pending <= expected_dispatches.size();
        end
    end

endmodule

// File: sim/tb_shortest_job_first_dispatcher_unit.sv
module tb_shortest_job_first_dispatcher_unit;

    import sjfd_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int RANDOM_REQUESTS = 950;
    localparam int CALM_TAIL       = 150;
    localparam int PAUSE_AT        = 400;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [55:0] s_tdata  = '0;
    logic        s_tuser  = REQ_INSERT;
    logic        m_tready = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [63:0] m_tdata;
    wire  [1:0]  m_tuser;

    int fail_count;
    int pending;
    bit calm        = 1'b0;
    int gap_pct     = 20;
    int stall_pct   = 20;
    int stall_left  = 0;
    int cycle_count = 0;
    int idle_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    shortest_job_first_dispatcher_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    sjfd_dispatch_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // response side back-pressure in bursts, with an intensity that is redrawn periodically
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 100 == 0)
        begin
            case ($urandom_range(0, 2))
                0:       stall_pct <= 0;
                1:       stall_pct <= 10;
                default: stall_pct <= 35;
            endcase
        end
        if (calm || !rst_n)
        begin
            m_tready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if ($urandom_range(0, 99) < stall_pct)
        begin
            stall_left <= $urandom_range(0, 8);
            m_tready   <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_shortest_job_first_dispatcher_unit: FAIL");
            $finish;
        end
    end

    task automatic send_request(logic kind, entry_t body);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= body;
        do
            @(posedge clk);
        while (!s_tready);
        if (!calm && $urandom_range(0, 99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    task automatic send_insert(int id, int burst, int pred, int later);
        entry_t e;
        e.id    = ID_W'(id);
        e.burst = BURST_W'(burst);
        e.pred  = BURST_W'(pred);
        e.later = BURST_W'(later);
        send_request(REQ_INSERT, e);
    endtask

    // predictions often clustered to force ties, bursts often near the prediction
    function automatic entry_t random_entry();
        entry_t e;
        int     d;
        e.id    = ID_W'($urandom_range(0, 255));
        e.later = BURST_W'($urandom_range(0, 65535));
        case ($urandom_range(0, 2))
            0:       e.pred = BURST_W'($urandom_range(0, 7));
            1:       e.pred = BURST_W'($urandom_range(0, 65535));
            default: e.pred = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
        endcase
        d = $urandom_range(0, 20);
        case ($urandom_range(0, 3))
            0:       e.burst = e.pred;
            1:       e.burst = BURST_W'($urandom_range(0, 65535));
            2:       e.burst = (int'(e.pred) + d > 65535) ? 16'hffff
                                                           : BURST_W'(int'(e.pred) + d);
            default: e.burst = (int'(e.pred) < d) ? 16'h0000 : BURST_W'(int'(e.pred) - d);
        endcase
        return e;
    endfunction

    initial
    begin
        entry_t e;
        logic   kind;
        int     insert_pct;
        insert_pct = 50;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // schedule on an empty table
        send_request(REQ_SCHEDULE, random_entry());
        // fill the table: extremes, ties, equal burst and prediction, splits
        send_insert(0, 0, 0, 0);
        send_insert(255, 65535, 65535, 65535);
        send_insert(1, 65535, 0, 65535);
        send_insert(2, 100, 100, 7);
        send_insert(3, 300, 100, 9);
        send_insert(4, 50, 100, 0);
        send_insert(5, 1, 65534, 3);
        for (int k = 7; k < SJFD_SLOTS; k++)
            send_request(REQ_INSERT, random_entry());
        // insert into a full table
        send_insert(170, 43690, 21845, 52428);
        repeat (6) send_request(REQ_SCHEDULE, random_entry());

        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            if (i % 40 == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       insert_pct = 85;
                    1:       insert_pct = 50;
                    2:       insert_pct = 20;
                    default: insert_pct = 60;
                endcase
                case ($urandom_range(0, 2))
                    0:       gap_pct = 0;
                    1:       gap_pct = 15;
                    default: gap_pct = 40;
                endcase
            end
            if (i == RANDOM_REQUESTS - CALM_TAIL)
                calm <= 1'b1;
            if (i == PAUSE_AT)
            begin
                // drain every outstanding response before carrying on
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (pending != 0) @(posedge clk);
            end
            kind = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_SCHEDULE;
            e    = random_entry();
            send_request(kind, e);
        end
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (3 * SJFD_SLOTS) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("tb_shortest_job_first_dispatcher_unit: PASS");
        else
            $display("tb_shortest_job_first_dispatcher_unit: FAIL");
        $finish;
    end

endmodule
